/* sv/c_subset_token_scanner_macros.svh */
// Assertion macros for the token scanner.
// Used by c_subset_token_scanner.sv; expects clk and rst_n in scope.
`ifndef C_SUBSET_TOKEN_SCANNER_MACROS_SVH
`define C_SUBSET_TOKEN_SCANNER_MACROS_SVH

// cond must hold at every edge outside reset
`define CST_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold in the cycle after ante
`define CST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/ctok_pkg.sv */
// Types and constants for the C subset token scanner.
// No dependencies.
package ctok_pkg;

  localparam int POSITION_BITS = 16;
  localparam int LENGTH_BITS   = 16;
  localparam int KW_BYTES      = 6;

  // result queue
  localparam int QDEPTH    = 4;
  localparam int QIDX_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2
  } scan_mode_t;

  localparam logic [3:0] KIND_LBRACE  = 4'd0;
  localparam logic [3:0] KIND_RBRACE  = 4'd1;
  localparam logic [3:0] KIND_LPAREN  = 4'd2;
  localparam logic [3:0] KIND_RPAREN  = 4'd3;
  localparam logic [3:0] KIND_SEMI    = 4'd4;
  localparam logic [3:0] KIND_INT     = 4'd5;
  localparam logic [3:0] KIND_RETURN  = 4'd6;
  localparam logic [3:0] KIND_VOID    = 4'd7;
  localparam logic [3:0] KIND_IDENT   = 4'd8;
  localparam logic [3:0] KIND_INTEGER = 4'd9;
  localparam logic [3:0] KIND_ERROR   = 4'd10;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  localparam logic [8*KW_BYTES-1:0] KW_INT    = 48'h0000_0069_6E74;
  localparam logic [8*KW_BYTES-1:0] KW_RETURN = 48'h7265_7475_726E;
  localparam logic [8*KW_BYTES-1:0] KW_VOID   = 48'h0000_766F_6964;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_marker;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] token_length;
    logic        last_of_run;
  } out_tok_t;

  function automatic logic is_alpha_u(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == CH_USCORE;
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

/* sv/c_subset_token_scanner.sv */
// Top level of the C subset token scanner: input register, scanner state,
// result queue. Depends on ctok_pkg and c_subset_token_scanner_macros.svh.
//
// Usage
//   Input: one source byte per transfer on in_data (char_code, end_marker).
//   A transfer with end_marker set flushes any pending identifier/number and
//   returns the position to line 1, column 1; char_code is then ignored.
//   Output: one token per transfer on out_data. Each input byte gives zero,
//   one or two tokens; last_of_run marks the final token of a byte.
//   Path: a byte is taken into the input register and scanned from there;
//   its tokens enter the result queue, from whose head they are taken.
//   Throughput: one byte per cycle while bytes give at most one token each
//   and out_stall stays low; a byte that gives two tokens is absorbed by the
//   four-entry result queue. The input register advances only when the
//   queue has two free entries.
//   Stall: out_stall holds the queue head; once fewer than two entries are
//   free, in_stall rises and the held byte waits in the input register.
//   Reset (rst_n low, synchronous): queue empty, no byte held, no token
//   pending, position line 1 column 1.
`include "c_subset_token_scanner_macros.svh"

module c_subset_token_scanner (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ctok_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ctok_pkg::out_tok_t out_data
);
  import ctok_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [LENGTH_BITS-1:0]   LEN_MAX = '1;
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
  localparam logic [QCNT_BITS-1:0]     Q_ROOM  = QCNT_BITS'(QDEPTH - 2);

  // input register
  in_item_t item_r;
  logic     item_vld_r, item_vld_nxt;

  // scanner state
  scan_mode_t                 mode_r, mode_nxt;
  logic [POSITION_BITS-1:0]   line_r, line_nxt;
  logic [POSITION_BITS-1:0]   col_r, col_nxt;
  logic [POSITION_BITS-1:0]   pline_r, pline_nxt;
  logic [POSITION_BITS-1:0]   pcol_r, pcol_nxt;
  logic [LENGTH_BITS-1:0]     plen_r, plen_nxt;
  logic [8*KW_BYTES-1:0]      kw_r, kw_nxt;

  // result queue
  out_tok_t               q_r [QDEPTH];
  logic [QIDX_BITS-1:0]   wp_r, rp_r;
  logic [QCNT_BITS-1:0]   q_cnt_r;

  logic     room, adv, pop;
  logic     push_a, push_b;     // a: flushed pending token, b: symbol/error
  out_tok_t tok_a, tok_b;
  logic [1:0] n_push;

  assign room     = (q_cnt_r <= Q_ROOM);
  assign adv      = item_vld_r && room;
  assign in_stall = item_vld_r && !room;
  assign out_valid = (q_cnt_r != '0);
  assign out_data  = q_r[rp_r];
  assign pop       = out_valid && !out_stall;
  assign n_push    = {1'b0, push_a} + {1'b0, push_b};

  // hold or take a byte
  assign item_vld_nxt = (in_valid && !in_stall) || (item_vld_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
    end
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

  // scan one byte against the pending token
  always_comb begin
    logic [7:0] c;
    logic       pend, alnum, cont;
    logic [3:0] pkind, skind;
    c      = item_r.char_code;
    pend   = (mode_r != MODE_IDLE);
    alnum  = is_alpha_u(c) || is_dig(c);
    cont   = (mode_r == MODE_IDENT && alnum) || (mode_r == MODE_NUMBER && is_dig(c));

    // kind of the pending token
    if (mode_r == MODE_NUMBER) begin
      pkind = KIND_INTEGER;
    end else if (plen_r == LENGTH_BITS'(3) && kw_r == KW_INT) begin
      pkind = KIND_INT;
    end else if (plen_r == LENGTH_BITS'(6) && kw_r == KW_RETURN) begin
      pkind = KIND_RETURN;
    end else if (plen_r == LENGTH_BITS'(4) && kw_r == KW_VOID) begin
      pkind = KIND_VOID;
    end else begin
      pkind = KIND_IDENT;
    end

    unique case (c)
      CH_LBRACE: skind = KIND_LBRACE;
      CH_RBRACE: skind = KIND_RBRACE;
      CH_LPAREN: skind = KIND_LPAREN;
      CH_RPAREN: skind = KIND_RPAREN;
      CH_SEMI:   skind = KIND_SEMI;
      default:   skind = KIND_ERROR;
    endcase

    mode_nxt  = mode_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    pline_nxt = pline_r;
    pcol_nxt  = pcol_r;
    plen_nxt  = plen_r;
    kw_nxt    = kw_r;
    push_a    = 1'b0;
    push_b    = 1'b0;

    tok_a.token_kind   = pkind;
    tok_a.start_line   = 16'(pline_r);
    tok_a.start_column = 16'(pcol_r);
    tok_a.token_length = 16'(plen_r);
    tok_a.last_of_run  = 1'b1;

    tok_b.token_kind   = skind;
    tok_b.start_line   = 16'(line_r);
    tok_b.start_column = 16'(col_r);
    tok_b.token_length = 16'd1;
    tok_b.last_of_run  = 1'b1;

    if (adv) begin
      if (item_r.end_marker) begin
        push_a    = pend;
        mode_nxt  = MODE_IDLE;
        pline_nxt = '0;
        pcol_nxt  = '0;
        plen_nxt  = '0;
        kw_nxt    = '0;
        line_nxt  = POS_ONE;
        col_nxt   = POS_ONE;
      end else begin
        if (cont) begin
          if (plen_r != LEN_MAX) plen_nxt = plen_r + 1'b1;
          kw_nxt = {kw_r[8*KW_BYTES-9:0], c};
        end else begin
          push_a    = pend;
          mode_nxt  = MODE_IDLE;
          pline_nxt = '0;
          pcol_nxt  = '0;
          plen_nxt  = '0;
          kw_nxt    = '0;
          if (is_blank(c)) begin
            // skipped
          end else if (alnum) begin
            mode_nxt  = is_dig(c) ? MODE_NUMBER : MODE_IDENT;
            pline_nxt = line_r;
            pcol_nxt  = col_r;
            plen_nxt  = LENGTH_BITS'(1);
            kw_nxt    = {{(8*KW_BYTES-8){1'b0}}, c};
          end else begin
            push_b = 1'b1;
          end
        end
        // advance position
        if (c == CH_LF) begin
          if (line_r != POS_MAX) line_nxt = line_r + 1'b1;
          col_nxt = POS_ONE;
        end else if (col_r != POS_MAX) begin
          col_nxt = col_r + 1'b1;
        end
      end
    end
    tok_a.last_of_run = !push_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      line_r  <= POS_ONE;
      col_r   <= POS_ONE;
      pline_r <= '0;
      pcol_r  <= '0;
      plen_r  <= '0;
      kw_r    <= '0;
    end else begin
      mode_r  <= mode_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      pline_r <= pline_nxt;
      pcol_r  <= pcol_nxt;
      plen_r  <= plen_nxt;
      kw_r    <= kw_nxt;
    end
  end

  // result queue: up to two writes, one read per cycle
  always_ff @(posedge clk) begin
    if (push_a) begin
      q_r[wp_r] <= tok_a;
    end
    if (push_b) begin
      q_r[push_a ? wp_r + 1'b1 : wp_r] <= tok_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      q_cnt_r <= '0;
    end else begin
      wp_r    <= wp_r + QIDX_BITS'(n_push);
      rp_r    <= rp_r + QIDX_BITS'(pop);
      q_cnt_r <= q_cnt_r + QCNT_BITS'(n_push) - QCNT_BITS'(pop);
    end
  end

  `CST_ASSERT(a_q_bound, q_cnt_r <= QCNT_BITS'(QDEPTH), "result queue overfilled")
  `CST_ASSERT(a_adv_room, !adv || q_cnt_r <= Q_ROOM, "byte scanned without queue room")
  `CST_ASSERT_NEXT(a_drain, pop && q_cnt_r == QCNT_BITS'(1) && n_push == 2'd0, !out_valid, "queue not empty after last pop")
  `CST_ASSERT_NEXT(a_end_clear, adv && item_r.end_marker, mode_r == MODE_IDLE && line_r == POS_ONE && col_r == POS_ONE, "end marker did not reset scanner")
  `CST_ASSERT(a_kind_range, !out_valid || out_data.token_kind <= KIND_ERROR, "token kind out of range")

endmodule
